// File: rtl/ethernet_ipv4_pair_extractor_top_assert.svh
// Assertion macros for the Ethernet/IPv4 address-pair extractor.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef ETHERNET_IPV4_PAIR_EXTRACTOR_TOP_ASSERT_SVH
`define ETHERNET_IPV4_PAIR_EXTRACTOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define EIPX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define EIPX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EIPX_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define EIPX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/eipx_pkg.sv
// Shared types and constants for the Ethernet/IPv4 address-pair extractor.
// No dependencies; imported by the parser, the output buffer and the top level.
`default_nettype none
package eipx_pkg;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_QINQ = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_POS  = 16'd12;
  localparam logic [15:0] ADDR_POS  = 16'd26;
  localparam logic [15:0] TYPE_END  = 16'd14;
  localparam logic [15:0] ADDR_END  = 16'd34;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'b001,
    PH_LEN_HI = 3'b010,
    PH_FRAME  = 3'b100
  } phase_t;

  typedef struct packed {
    logic        is_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [1:0]  tags_seen;
    logic        too_short;
    logic [31:0] total_frames;
    logic [31:0] non_ipv4_frames;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage
`default_nettype wire

// File: rtl/eipx_parser.sv
// Per-byte record parser: length header, tag skipping, address capture, totals.
// Depends on eipx_pkg; emits one result beat in the cycle the record's last byte is taken.
`default_nettype none
module eipx_parser import eipx_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_take,
  input  wire logic [7:0] rec_byte,
  output logic            res_push,
  output result_t         res
);

  phase_t                 phase, phase_next;
  logic [7:0]             len_low_byte, len_low_byte_next;
  logic [15:0]            record_length, record_length_next;
  logic [15:0]            byte_position, byte_position_next;
  logic [15:0]            outer_type, outer_type_next;
  logic [15:0]            final_type, final_type_next;
  logic [1:0]             tag_count, tag_count_next;
  logic [63:0]            addr_pair, addr_pair_next;
  logic [COUNT_WIDTH-1:0] frames_done, frames_done_next;
  logic [COUNT_WIDTH-1:0] non_ipv4_done, non_ipv4_done_next;

  logic                   finish;
  logic [15:0]            tag_offset;
  logic [15:0]            tpos, apos;
  logic [15:0]            joined_type;
  logic                   type_done, addr_done, ipv4, short_rec;
  logic [1:0]             tags_final;
  logic [63:0]            addr_final;
  logic [31:0]            total32, non32;

  always_comb begin
    phase_next         = phase;
    len_low_byte_next  = len_low_byte;
    record_length_next = record_length;
    byte_position_next = byte_position;
    outer_type_next    = outer_type;
    final_type_next    = final_type;
    tag_count_next     = tag_count;
    addr_pair_next     = addr_pair;
    finish             = 1'b0;
    tag_offset         = {12'd0, tag_count, 2'b00};
    tpos               = TYPE_POS + tag_offset;
    apos               = ADDR_POS + tag_offset;
    joined_type        = {final_type[15:8], rec_byte};

    case (phase)
      PH_LEN_LO: begin
        len_low_byte_next = rec_byte;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        record_length_next = {rec_byte, len_low_byte};
        byte_position_next = '0;
        outer_type_next    = '0;
        final_type_next    = '0;
        tag_count_next     = '0;
        addr_pair_next     = '0;
        phase_next         = PH_FRAME;
        finish             = ({rec_byte, len_low_byte} == 16'd0);
      end
      PH_FRAME: begin
        if (byte_position == tpos) begin
          final_type_next = {rec_byte, 8'd0};
        end else if (byte_position == tpos + 16'd1) begin
          final_type_next = joined_type;
          if (tag_count == 2'd0 && (joined_type == TYPE_VLAN || joined_type == TYPE_QINQ)) begin
            outer_type_next = joined_type;
            tag_count_next  = 2'd1;
          end else if (tag_count == 2'd1 && outer_type == TYPE_QINQ &&
                       joined_type == TYPE_VLAN) begin
            tag_count_next = 2'd2;
          end
        end else if (byte_position >= apos && byte_position < apos + 16'd8) begin
          addr_pair_next = {addr_pair[55:0], rec_byte};
        end
        byte_position_next = byte_position + 16'd1;
        finish             = (byte_position_next >= record_length);
      end
      default: begin
        phase_next = PH_LEN_LO;
      end
    endcase

    type_done  = byte_position_next >= TYPE_END + {12'd0, tag_count_next, 2'b00};
    addr_done  = byte_position_next >= ADDR_END + {12'd0, tag_count_next, 2'b00};
    ipv4       = type_done && final_type_next == TYPE_IPV4 && addr_done;
    short_rec  = !type_done || (final_type_next == TYPE_IPV4 && !addr_done);
    tags_final = tag_count_next;
    addr_final = addr_pair_next;

    frames_done_next   = frames_done;
    non_ipv4_done_next = non_ipv4_done;
    if (finish) begin
      if (frames_done != '1) begin
        frames_done_next = frames_done + 1'b1;
      end
      if (!ipv4 && non_ipv4_done != '1) begin
        non_ipv4_done_next = non_ipv4_done + 1'b1;
      end
      byte_position_next = '0;
      outer_type_next    = '0;
      final_type_next    = '0;
      tag_count_next     = '0;
      addr_pair_next     = '0;
      phase_next         = PH_LEN_LO;
    end
  end

  generate
    if (COUNT_WIDTH > 32) begin : g_sat
      assign total32 = (|frames_done_next[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                             : frames_done_next[31:0];
      assign non32   = (|non_ipv4_done_next[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                               : non_ipv4_done_next[31:0];
    end else begin : g_ext
      assign total32 = 32'(frames_done_next);
      assign non32   = 32'(non_ipv4_done_next);
    end
  endgenerate

  assign res_push            = byte_take && finish;
  assign res.is_ipv4         = ipv4;
  assign res.src_addr        = ipv4 ? addr_final[63:32] : 32'd0;
  assign res.dst_addr        = ipv4 ? addr_final[31:0] : 32'd0;
  assign res.tags_seen       = tags_final;
  assign res.too_short       = short_rec;
  assign res.total_frames    = total32;
  assign res.non_ipv4_frames = non32;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN_LO;
      len_low_byte  <= '0;
      record_length <= '0;
      byte_position <= '0;
      outer_type    <= '0;
      final_type    <= '0;
      tag_count     <= '0;
      addr_pair     <= '0;
      frames_done   <= '0;
      non_ipv4_done <= '0;
    end else if (byte_take) begin
      phase         <= phase_next;
      len_low_byte  <= len_low_byte_next;
      record_length <= record_length_next;
      byte_position <= byte_position_next;
      outer_type    <= outer_type_next;
      final_type    <= final_type_next;
      tag_count     <= tag_count_next;
      addr_pair     <= addr_pair_next;
      frames_done   <= frames_done_next;
      non_ipv4_done <= non_ipv4_done_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/eipx_outbuf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on eipx_pkg; lets the parser keep taking bytes while a result waits.
`default_nettype none
module eipx_outbuf import eipx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop_stall,
  output result_t      head,
  output buf_status_t  status
);

  result_t main_data, skid_data;
  logic    main_valid, skid_valid;
  logic    pop;

  assign pop    = main_valid && !pop_stall;
  assign head   = main_data;
  assign status = '{main_valid: main_valid, skid_valid: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ethernet_ipv4_pair_extractor_top.sv
// Ethernet/IPv4 address-pair extractor: one stream byte per beat, one result per record.
// A record is a 16-bit little-endian length followed by that many frame bytes. The block
// takes one byte per cycle when not stalled; the parser's state registers advance once per
// byte, and a record's result is pushed to the output buffer when its last byte is taken
// (the length high byte for a zero-length record). Results go through a two-entry buffer,
// so the input stalls only when two results are waiting. Totals count internally at COUNT_WIDTH
// bits and are reported saturated to 32 bits. Depends on eipx_pkg, eipx_parser, eipx_outbuf.
`default_nettype none
`include "ethernet_ipv4_pair_extractor_top_assert.svh"
module ethernet_ipv4_pair_extractor_top import eipx_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rec_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_ipv4,
  output logic [31:0]      src_addr,
  output logic [31:0]      dst_addr,
  output logic [1:0]       tags_seen,
  output logic             too_short,
  output logic [31:0]      total_frames,
  output logic [31:0]      non_ipv4_frames
);

  logic        byte_take;
  logic        res_push;
  result_t     res;
  result_t     head;
  buf_status_t status;

  assign in_stall  = status.skid_valid;
  assign byte_take = in_valid && !in_stall;

  eipx_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rec_byte  (rec_byte),
    .res_push  (res_push),
    .res       (res)
  );

  eipx_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop_stall (out_stall),
    .head      (head),
    .status    (status)
  );

  assign out_valid       = status.main_valid;
  assign is_ipv4         = head.is_ipv4;
  assign src_addr        = head.src_addr;
  assign dst_addr        = head.dst_addr;
  assign tags_seen       = head.tags_seen;
  assign too_short       = head.too_short;
  assign total_frames    = head.total_frames;
  assign non_ipv4_frames = head.non_ipv4_frames;

  `EIPX_ASSERT_SAME(a_stall_needs_result, clk, rst, in_stall, out_valid, "stall without a waiting result")
  `EIPX_ASSERT_NEXT(a_full_after_push, clk, rst, out_valid && out_stall && res_push, in_stall, "buffer did not fill on a blocked push")
  `EIPX_ASSERT_SAME(a_ipv4_complete, clk, rst, out_valid && is_ipv4, !too_short && total_frames != 32'd0, "IPv4 result marked short or uncounted")

endmodule
`default_nettype wire

// File: verif/ethernet_ipv4_pair_extractor_top_tb.sv
// Self-checking testbench for ethernet_ipv4_pair_extractor_top: drives record byte streams and
// checks every per-record result against a behavioral parser kept inside the bench.
// Depends on eipx_pkg and on the RTL of ethernet_ipv4_pair_extractor_top.
module ethernet_ipv4_pair_extractor_top_tb;
  import eipx_pkg::*;

  localparam int COUNT_WIDTH = 32;
  localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rec_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_ipv4;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [1:0]  tags_seen;
  logic        too_short;
  logic [31:0] total_frames;
  logic [31:0] non_ipv4_frames;

  ethernet_ipv4_pair_extractor_top #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rec_byte(rec_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_ipv4(is_ipv4), .src_addr(src_addr), .dst_addr(dst_addr),
    .tags_seen(tags_seen), .too_short(too_short),
    .total_frames(total_frames), .non_ipv4_frames(non_ipv4_frames)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic [7:0] data;
    int         gap;
    bit         drain;
  } feed_t;

  feed_t      feed_q[$];
  feed_t      cur_beat;
  bit         cur_pending = 1'b0;
  bit         byte_taken = 1'b0;
  bit         result_taken = 1'b0;
  bit         drain_next = 1'b0;
  int         tx_max = 16;
  int         bytes_fed = 0;
  int         rx_beats = 0;
  int         rx_stall_left = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic [7:0] frame_buf[$];
  result_t    expected_q[$];
  result_t    oldest_want;

  // Parser state mirrored from the block.
  phase_t      ps_phase = PH_LEN_LO;
  logic [7:0]  ps_len_lo = '0;
  logic [15:0] ps_len = '0;
  logic [15:0] ps_pos = '0;
  logic [15:0] ps_outer = '0;
  logic [15:0] ps_type = '0;
  logic [1:0]  ps_tags = '0;
  logic [63:0] ps_addr = '0;
  logic [63:0] ps_frames = '0;
  logic [63:0] ps_non_ipv4 = '0;

  function automatic logic [63:0] bump(input logic [63:0] v);
    return (v < COUNT_MAX) ? v + 64'd1 : v;
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_frame_state();
    ps_pos = '0;
    ps_outer = '0;
    ps_type = '0;
    ps_tags = '0;
    ps_addr = '0;
  endtask

  task automatic close_record();
    logic [16:0] type_end;
    logic [16:0] addr_end;
    logic        type_done;
    logic        addr_done;
    logic        ipv4;
    result_t     r;
    type_end = 17'(TYPE_END) + 17'(ps_tags) * 17'd4;
    addr_end = 17'(ADDR_END) + 17'(ps_tags) * 17'd4;
    type_done = {1'b0, ps_pos} >= type_end;
    addr_done = {1'b0, ps_pos} >= addr_end;
    ipv4 = type_done && (ps_type == TYPE_IPV4) && addr_done;
    ps_frames = bump(ps_frames);
    if (!ipv4) ps_non_ipv4 = bump(ps_non_ipv4);
    r.is_ipv4 = ipv4;
    r.src_addr = ipv4 ? ps_addr[63:32] : 32'h0;
    r.dst_addr = ipv4 ? ps_addr[31:0] : 32'h0;
    r.tags_seen = ps_tags;
    r.too_short = !type_done || ((ps_type == TYPE_IPV4) && !addr_done);
    r.total_frames = clip32(ps_frames);
    r.non_ipv4_frames = clip32(ps_non_ipv4);
    expected_q.push_back(r);
    clear_frame_state();
    ps_phase = PH_LEN_LO;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [16:0] p;
    logic [16:0] tpos;
    logic [16:0] apos;
    case (ps_phase)
      PH_LEN_LO: begin
        ps_len_lo = b;
        ps_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        ps_len = {b, ps_len_lo};
        clear_frame_state();
        ps_phase = PH_FRAME;
        if (ps_len == 16'd0) close_record();
      end
      PH_FRAME: begin
        p = {1'b0, ps_pos};
        tpos = 17'(TYPE_POS) + 17'(ps_tags) * 17'd4;
        apos = 17'(ADDR_POS) + 17'(ps_tags) * 17'd4;
        if (p == tpos) begin
          ps_type = {b, 8'h00};
        end else if (p == tpos + 17'd1) begin
          ps_type = ps_type | {8'h00, b};
          if (ps_tags == 2'd0 && (ps_type == TYPE_VLAN || ps_type == TYPE_QINQ)) begin
            ps_outer = ps_type;
            ps_tags = 2'd1;
          end else if (ps_tags == 2'd1 && ps_outer == TYPE_QINQ && ps_type == TYPE_VLAN) begin
            ps_tags = 2'd2;
          end
        end else if (p >= apos && p < apos + 17'd8) begin
          ps_addr = {ps_addr[55:0], b};
        end
        ps_pos = ps_pos + 16'd1;
        if (ps_pos >= ps_len) close_record();
      end
      default: ps_phase = PH_LEN_LO;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
    mismatch_count++;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    feed_t f;
    f.data = b;
    f.gap = $urandom_range(0, tx_max);
    f.drain = drain_next;
    drain_next = 1'b0;
    feed_q.push_back(f);
    bytes_fed++;
  endtask

  // Builds a frame in frame_buf: MAC addresses, a chain of type fields (each but the
  // last followed by a two-byte tag control field), the rest of the IPv4 header with
  // both addresses, then trailing payload.
  task automatic make_frame(input int ntypes, input logic [15:0] t0, input logic [15:0] t1,
                            input logic [15:0] t2, input logic [31:0] src,
                            input logic [31:0] dst, input int extra);
    logic [15:0] ty;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom));
    for (int i = 0; i < ntypes; i++) begin
      ty = (i == 0) ? t0 : (i == 1) ? t1 : t2;
      frame_buf.push_back(ty[15:8]);
      frame_buf.push_back(ty[7:0]);
      if (i < ntypes - 1) repeat (2) frame_buf.push_back(8'($urandom));
    end
    repeat (12) frame_buf.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) frame_buf.push_back(src[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(dst[8*i +: 8]);
    repeat (extra) frame_buf.push_back(8'($urandom));
  endtask

  task automatic send_record(input int n);
    feed_byte(n[7:0]);
    feed_byte(n[15:8]);
    for (int i = 0; i < n; i++) feed_byte((i < frame_buf.size()) ? frame_buf[i] : 8'($urandom));
  endtask

  function automatic logic [31:0] any_addr();
    int pick;
    pick = $urandom_range(0, 9);
    return (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
  endfunction

  function automatic logic [15:0] any_type();
    int pick;
    pick = $urandom_range(0, 3);
    return (pick == 0) ? TYPE_VLAN : (pick == 1) ? TYPE_QINQ :
           (pick == 2) ? TYPE_IPV4 : 16'($urandom);
  endfunction

  task automatic random_record();
    logic [15:0] last_type;
    int          shape;
    int          extra;
    int          full_len;
    int          len_pick;
    last_type = ($urandom_range(0, 9) < 7) ? TYPE_IPV4 : 16'($urandom);
    extra = $urandom_range(0, 6);
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1:    make_frame(1, last_type, '0, '0, any_addr(), any_addr(), extra);
      2, 3:    make_frame(2, TYPE_VLAN, last_type, '0, any_addr(), any_addr(), extra);
      4, 5:    make_frame(2, TYPE_QINQ, last_type, '0, any_addr(), any_addr(), extra);
      6, 7, 8: make_frame(3, TYPE_QINQ, TYPE_VLAN, last_type, any_addr(), any_addr(), extra);
      default: make_frame(3, any_type(), any_type(), any_type(), any_addr(), any_addr(), extra);
    endcase
    full_len = frame_buf.size();
    len_pick = $urandom_range(0, 9);
    case (len_pick)
      0, 1, 2, 3, 4, 5: send_record(full_len);
      6:                send_record(0);
      7:                send_record($urandom_range(0, full_len - 1));
      8:                send_record(full_len + $urandom_range(0, 20));
      default:          send_record($urandom_range(0, 63));
    endcase
  endtask

  task automatic wait_all_done();
    while (feed_q.size() != 0 || cur_pending || in_valid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    byte_taken = !rst && in_valid && !in_stall;
    if (byte_taken) parse_byte(rec_byte);
  end

  always @(negedge clk) begin
    if (!(in_valid && !byte_taken)) begin
      if (!cur_pending && feed_q.size() != 0) begin
        cur_beat = feed_q.pop_front();
        cur_pending = 1'b1;
      end
      if (cur_pending && cur_beat.gap == 0 && !(cur_beat.drain && expected_q.size() != 0)) begin
        in_valid <= 1'b1;
        rec_byte <= cur_beat.data;
        cur_pending = 1'b0;
      end else begin
        in_valid <= 1'b0;
        rec_byte <= 8'($urandom);
        if (cur_pending && cur_beat.gap > 0) cur_beat.gap--;
      end
    end
  end

  always @(posedge clk) begin
    result_taken = !rst && out_valid && !out_stall;
    if (result_taken) begin
      rx_beats++;
      if (expected_q.size() == 0) begin
        flag_mismatch("result beat with none pending", 32'h0, 32'h0);
      end else begin
        oldest_want = expected_q.pop_front();
        if (is_ipv4 !== oldest_want.is_ipv4)
          flag_mismatch("is_ipv4", 32'(is_ipv4), 32'(oldest_want.is_ipv4));
        if (src_addr !== oldest_want.src_addr)
          flag_mismatch("src_addr", src_addr, oldest_want.src_addr);
        if (dst_addr !== oldest_want.dst_addr)
          flag_mismatch("dst_addr", dst_addr, oldest_want.dst_addr);
        if (tags_seen !== oldest_want.tags_seen)
          flag_mismatch("tags_seen", 32'(tags_seen), 32'(oldest_want.tags_seen));
        if (too_short !== oldest_want.too_short)
          flag_mismatch("too_short", 32'(too_short), 32'(oldest_want.too_short));
        if (total_frames !== oldest_want.total_frames)
          flag_mismatch("total_frames", total_frames, oldest_want.total_frames);
        if (non_ipv4_frames !== oldest_want.non_ipv4_frames)
          flag_mismatch("non_ipv4_frames", non_ipv4_frames, oldest_want.non_ipv4_frames);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (result_taken)
      rx_stall_left = (((rx_beats / 40) % 3) == 1) ? 0 : $urandom_range(0, 16);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int recs;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    frame_buf.delete();
    send_record(0);
    make_frame(1, TYPE_IPV4, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_record(34);
    make_frame(1, TYPE_IPV4, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF, 5);
    send_record(frame_buf.size());
    make_frame(2, TYPE_VLAN, TYPE_IPV4, '0, any_addr(), any_addr(), 0);
    send_record(frame_buf.size());
    make_frame(3, TYPE_QINQ, TYPE_VLAN, TYPE_IPV4, any_addr(), any_addr(), 2);
    send_record(frame_buf.size());
    make_frame(2, TYPE_QINQ, TYPE_IPV4, '0, any_addr(), any_addr(), 0);
    send_record(frame_buf.size());
    make_frame(1, 16'h86DD, '0, '0, any_addr(), any_addr(), 0);
    send_record(frame_buf.size());
    make_frame(1, TYPE_IPV4, '0, '0, any_addr(), any_addr(), 0);
    send_record(33);
    send_record(13);
    make_frame(3, TYPE_VLAN, TYPE_VLAN, TYPE_IPV4, any_addr(), any_addr(), 0);
    send_record(frame_buf.size());
    make_frame(3, TYPE_QINQ, TYPE_QINQ, TYPE_IPV4, any_addr(), any_addr(), 0);
    send_record(frame_buf.size());
    make_frame(3, TYPE_QINQ, TYPE_VLAN, TYPE_IPV4, any_addr(), any_addr(), 0);
    send_record(41);
    make_frame(1, TYPE_IPV4, '0, '0, any_addr(), any_addr(), 0);
    send_record(100);
    wait_all_done();

    recs = 0;
    while (bytes_fed < 700) begin
      tx_max = ((recs % 3) == 2) ? 0 : 16;
      if (recs % 4 == 3) drain_next = 1'b1;
      random_record();
      recs++;
    end
    wait_all_done();

    // The receiver holds off while back-to-back records fill the output buffer.
    tx_max = 0;
    hold_req++;
    repeat (30) send_record(0);
    repeat (5) random_record();
    wait_all_done();

    make_frame(1, TYPE_IPV4, '0, '0, any_addr(), any_addr(), 0);
    send_record(16'h0101);
    wait_all_done();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
